// ===== sv/nfi_pkg.sv =====
// ----------------------------------------------------------------------------
// nfi_pkg: shared types and constants of the force integrator
// Widths, register indexes, request codes and the front/back queue types.
// ----------------------------------------------------------------------------
package nfi_pkg;

  localparam int DATA_W        = 32;  // Q15.16 state and vector width
  localparam int DT_W          = 16;  // time step, unsigned Q0.16
  localparam int FRAC_BITS_DEF = 16;  // default fraction bits of the vectors
  localparam int QUEUE_DEPTH   = 2;   // entries between front and back
  localparam int CFG_IDX_W     = 1;   // configuration register index width
  localparam int REQ_W         = 2;   // request type code width

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BODY_MASS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP = 1'b1;

  // Request type codes on the input channel
  localparam logic [REQ_W-1:0] REQ_CODE_FORCE = 2'd0;
  localparam logic [REQ_W-1:0] REQ_CODE_STEP  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CODE_LOAD  = 2'd2;

  // Register reset values
  localparam logic [DATA_W-1:0] MASS_RESET = 32'd65536;
  localparam logic [DT_W-1:0]   DT_RESET   = 16'd1092;

  // Classified request kind
  typedef enum logic [1:0] {
    KIND_FORCE,
    KIND_STEP,
    KIND_LOAD,
    KIND_NOP
  } req_kind_e;

  // One queued request
  typedef struct packed {
    req_kind_e                 kind;
    logic signed [DATA_W-1:0]  a_x;
    logic signed [DATA_W-1:0]  a_y;
    logic signed [DATA_W-1:0]  b_x;
    logic signed [DATA_W-1:0]  b_y;
  } req_t;

  // Head of the queue as seen by the back end
  typedef struct packed {
    logic valid;
    req_t req;
  } queue_head_t;

  // Back end sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_X,
    ST_DIV_Y,
    ST_MUL_A,
    ST_MUL_V,
    ST_MUL_A2,
    ST_UPDATE,
    ST_DONE
  } back_state_e;

endpackage

// ===== sv/nfi_if.sv =====
// ----------------------------------------------------------------------------
// nfi_if: channel interfaces of the force integrator
// Request, result and configuration write channels, valid/ready handshake.
// ----------------------------------------------------------------------------

// Request channel
interface nfi_req_if import nfi_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [REQ_W-1:0]         req_type;
  logic signed [DATA_W-1:0] vec_a_x;
  logic signed [DATA_W-1:0] vec_a_y;
  logic signed [DATA_W-1:0] vec_b_x;
  logic signed [DATA_W-1:0] vec_b_y;

  modport source (output valid, req_type, vec_a_x, vec_a_y, vec_b_x, vec_b_y,
                  input  ready);
  modport sink   (input  valid, req_type, vec_a_x, vec_a_y, vec_b_x, vec_b_y,
                  output ready);
endinterface

// Result channel
interface nfi_res_if import nfi_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] pos_x_out;
  logic signed [DATA_W-1:0] pos_y_out;
  logic signed [DATA_W-1:0] vel_x_out;
  logic signed [DATA_W-1:0] vel_y_out;
  logic signed [DATA_W-1:0] acc_x_out;
  logic signed [DATA_W-1:0] acc_y_out;
  logic                     zero_mass_error;
  logic                     saturated;

  modport source (output valid, pos_x_out, pos_y_out, vel_x_out, vel_y_out,
                         acc_x_out, acc_y_out, zero_mass_error, saturated,
                  input  ready);
  modport sink   (input  valid, pos_x_out, pos_y_out, vel_x_out, vel_y_out,
                         acc_x_out, acc_y_out, zero_mass_error, saturated,
                  output ready);
endinterface

// Configuration write channel
interface nfi_cfg_if import nfi_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [DATA_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input  valid, index, data, output ready);
endinterface

// ===== sv/nfi_front.sv =====
// ----------------------------------------------------------------------------
// nfi_front: request intake
// Accepts request transactions, classifies the type code and queues them
// for the back end.
// ----------------------------------------------------------------------------
module nfi_front import nfi_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  nfi_req_if.sink     req_i,
  output queue_head_t head_o,
  input  logic        pop_i
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  req_t             mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             push;
  logic             pop;
  req_t             in_req;

  // classify the incoming request
  always_comb begin
    in_req.a_x = req_i.vec_a_x;
    in_req.a_y = req_i.vec_a_y;
    in_req.b_x = req_i.vec_b_x;
    in_req.b_y = req_i.vec_b_y;
    unique case (req_i.req_type)
      REQ_CODE_FORCE: in_req.kind = KIND_FORCE;
      REQ_CODE_STEP:  in_req.kind = KIND_STEP;
      REQ_CODE_LOAD:  in_req.kind = KIND_LOAD;
      default:        in_req.kind = KIND_NOP;
    endcase
  end

  assign req_i.ready = (cnt_q != CNT_W'(QUEUE_DEPTH));
  assign push        = req_i.valid && req_i.ready;
  assign pop         = pop_i && (cnt_q != '0);

  // pointer and count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push && pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_req;
    end
  end

  assign head_o.valid = (cnt_q != '0);
  assign head_o.req   = mem_q[rd_ptr_q];

endmodule

// ===== sv/nfi_div.sv =====
// ----------------------------------------------------------------------------
// nfi_div: serial magnitude divider
// Restoring division of (mag << FRAC_BITS) by a 32 bit divisor, one
// quotient bit per cycle.
// ----------------------------------------------------------------------------
module nfi_div import nfi_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  localparam int NUM_W = DATA_W + FRAC_BITS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DATA_W-1:0] mag_i,
  input  logic [DATA_W-1:0] divisor_i,
  output logic              done_o,
  output logic [NUM_W-1:0]  quot_o
);

  localparam int CNT_W = $clog2(NUM_W);

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DATA_W-1:0] rem_q;
  logic [NUM_W-1:0]  num_q;
  logic [NUM_W-1:0]  quot_q;
  logic [DATA_W:0]   trial;
  logic              fits;
  logic [DATA_W:0]   rem_next;
  logic              last;

  // one restoring step
  assign trial    = {rem_q, num_q[NUM_W-1]};
  assign fits     = (trial >= {1'b0, divisor_i});
  assign rem_next = fits ? (trial - {1'b0, divisor_i}) : trial;
  assign last     = (cnt_q == CNT_W'(NUM_W - 1));

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && last;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (last) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= '0;
      num_q  <= {mag_i, {FRAC_BITS{1'b0}}};
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= rem_next[DATA_W-1:0];
      num_q  <= {num_q[NUM_W-2:0], 1'b0};
      quot_q <= {quot_q[NUM_W-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// ===== sv/nfi_back.sv =====
// ----------------------------------------------------------------------------
// nfi_back: execution back end
// Holds the body state and configuration, sequences force add, load and
// integration step through the divider and one shared multiplier, and
// registers the result transaction.
// ----------------------------------------------------------------------------
module nfi_back import nfi_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  queue_head_t head_i,
  output logic        pop_o,
  nfi_cfg_if.sink     cfg_i,
  nfi_res_if.source   res_o
);

  localparam int NUM_W  = DATA_W + FRAC_BITS;
  localparam int ADT_W  = DATA_W + DT_W;       // a*dt, v*dt
  localparam int ADT2_W = DATA_W + 2 * DT_W;   // a*dt*dt
  localparam int PROD_W = ADT_W + DT_W + 1;
  localparam int SUM_W  = DATA_W + 4;
  localparam logic signed [ADT_W:0]  HALF_DT  = (ADT_W + 1)'(2 ** (DT_W - 1));
  localparam logic signed [ADT2_W:0] HALF_DT2 = (ADT2_W + 1)'(64'd1 << (2 * DT_W));
  localparam logic signed [DATA_W-1:0] S_MAX = {1'b0, {(DATA_W - 1){1'b1}}};
  localparam logic signed [DATA_W-1:0] S_MIN = {1'b1, {(DATA_W - 1){1'b0}}};

  // clip check and clip value of a wide signed sum
  function automatic logic ovf(input logic signed [SUM_W-1:0] x);
    ovf = !((&x[SUM_W-1:DATA_W-1]) || !(|x[SUM_W-1:DATA_W-1]));
  endfunction

  function automatic logic signed [DATA_W-1:0] sat(input logic signed [SUM_W-1:0] x);
    if (ovf(x)) begin
      sat = x[SUM_W-1] ? S_MIN : S_MAX;
    end else begin
      sat = x[DATA_W-1:0];
    end
  endfunction

  back_state_e state_q, state_d;

  // configuration
  logic [DATA_W-1:0] mass_q;
  logic [DT_W-1:0]   dt_q;

  // body state
  logic signed [DATA_W-1:0] pos_x_q, pos_y_q, vel_x_q, vel_y_q;
  logic signed [DATA_W-1:0] acc_x_q, acc_y_q, fsum_x_q, fsum_y_q;
  logic                     axis_q;
  logic                     err_q, sat_q;

  // products
  logic signed [ADT_W-1:0]  adt_q, vdt_q;
  logic signed [ADT2_W-1:0] adt2_q;

  // result register
  logic                     res_valid_q;
  logic signed [DATA_W-1:0] res_pos_x_q, res_pos_y_q, res_vel_x_q, res_vel_y_q;
  logic signed [DATA_W-1:0] res_acc_x_q, res_acc_y_q;
  logic                     res_err_q, res_sat_q;

  logic              div_start;
  logic              div_done;
  logic [NUM_W-1:0]  quot;
  logic [DATA_W-1:0] div_src;
  logic [DATA_W-1:0] div_mag;
  logic              div_neg;
  logic              q_hi_any, pos_ovf, neg_ovf, acc_ovf;
  logic signed [DATA_W-1:0] acc_val;
  logic              out_load;
  logic              mass_zero;

  logic signed [SUM_W-1:0]  fadd_x, fadd_y;
  logic signed [DATA_W-1:0] a_sel, v_sel, p_sel;
  logic signed [ADT_W-1:0]  mul_a;
  logic signed [DT_W:0]     mul_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [ADT_W:0]    vdt_rnd, adt_rnd;
  logic signed [ADT2_W:0]   adt2_rnd;
  logic signed [DATA_W:0]   v_inc, a_inc;
  logic signed [DATA_W-1:0] p_inc2;
  logic signed [SUM_W-1:0]  np, nv;

  assign mass_zero = (mass_q == '0);

  // configuration writes
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mass_q <= MASS_RESET;
      dt_q   <= DT_RESET;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_BODY_MASS: mass_q <= cfg_i.data;
        CFG_TIME_STEP: dt_q   <= cfg_i.data[DT_W-1:0];
      endcase
    end
  end

  // divider operand and signed acceleration from the quotient
  assign div_src = (state_q == ST_IDLE) ? fsum_x_q : fsum_y_q;
  assign div_mag = div_src[DATA_W-1] ? (~div_src + 1'b1) : div_src;
  assign div_neg = (state_q == ST_DIV_Y) ? fsum_y_q[DATA_W-1] : fsum_x_q[DATA_W-1];
  assign q_hi_any = |quot[NUM_W-1:DATA_W];
  assign pos_ovf  = q_hi_any || quot[DATA_W-1];
  assign neg_ovf  = q_hi_any || (quot[DATA_W-1] && (|quot[DATA_W-2:0]));
  assign acc_ovf  = div_neg ? neg_ovf : pos_ovf;
  assign acc_val  = div_neg ? (neg_ovf ? S_MIN : -$signed(quot[DATA_W-1:0]))
                            : (pos_ovf ? S_MAX : $signed(quot[DATA_W-1:0]));

  nfi_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .mag_i     (div_mag),
    .divisor_i (mass_q),
    .done_o    (div_done),
    .quot_o    (quot)
  );

  // force accumulation sums
  assign fadd_x = {{(SUM_W - DATA_W){fsum_x_q[DATA_W-1]}}, fsum_x_q}
                + {{(SUM_W - DATA_W){head_i.req.a_x[DATA_W-1]}}, head_i.req.a_x};
  assign fadd_y = {{(SUM_W - DATA_W){fsum_y_q[DATA_W-1]}}, fsum_y_q}
                + {{(SUM_W - DATA_W){head_i.req.a_y[DATA_W-1]}}, head_i.req.a_y};

  // shared multiplier: operand chosen by step
  assign a_sel = axis_q ? acc_y_q : acc_x_q;
  assign v_sel = axis_q ? vel_y_q : vel_x_q;
  assign p_sel = axis_q ? pos_y_q : pos_x_q;
  assign mul_b = $signed({1'b0, dt_q});

  always_comb begin
    unique case (state_q)
      ST_MUL_V:  mul_a = {{(ADT_W - DATA_W){v_sel[DATA_W-1]}}, v_sel};
      ST_MUL_A2: mul_a = adt_q;
      default:   mul_a = {{(ADT_W - DATA_W){a_sel[DATA_W-1]}}, a_sel};
    endcase
  end

  assign prod = mul_a * mul_b;

  // round to nearest, ties up, then the per-axis update sums
  assign vdt_rnd  = {vdt_q[ADT_W-1], vdt_q} + HALF_DT;
  assign adt_rnd  = {adt_q[ADT_W-1], adt_q} + HALF_DT;
  assign adt2_rnd = {adt2_q[ADT2_W-1], adt2_q} + HALF_DT2;
  assign v_inc    = $signed(vdt_rnd[ADT_W:DT_W]);
  assign a_inc    = $signed(adt_rnd[ADT_W:DT_W]);
  assign p_inc2   = $signed(adt2_rnd[ADT2_W:2 * DT_W + 1]);

  assign np = {{(SUM_W - DATA_W){p_sel[DATA_W-1]}}, p_sel}
            + {{(SUM_W - DATA_W - 1){v_inc[DATA_W]}}, v_inc}
            + {{(SUM_W - DATA_W){p_inc2[DATA_W-1]}}, p_inc2};
  assign nv = {{(SUM_W - DATA_W){v_sel[DATA_W-1]}}, v_sel}
            + {{(SUM_W - DATA_W - 1){a_inc[DATA_W]}}, a_inc};

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (head_i.valid) begin
          if (head_i.req.kind == KIND_STEP && !mass_zero) begin
            state_d = ST_DIV_X;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_DIV_X: begin
        if (div_done) begin
          state_d = ST_DIV_Y;
        end
      end
      ST_DIV_Y: begin
        if (div_done) begin
          state_d = ST_MUL_A;
        end
      end
      ST_MUL_A:  state_d = ST_MUL_V;
      ST_MUL_V:  state_d = ST_MUL_A2;
      ST_MUL_A2: state_d = ST_UPDATE;
      ST_UPDATE: state_d = axis_q ? ST_DONE : ST_MUL_A;
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    pop_o     = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        pop_o     = head_i.valid;
        div_start = head_i.valid && (head_i.req.kind == KIND_STEP) && !mass_zero;
      end
      ST_DIV_X: div_start = div_done;
      ST_DONE:  out_load  = !res_valid_q || res_o.ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // body state and flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q  <= '0;
      pos_y_q  <= '0;
      vel_x_q  <= '0;
      vel_y_q  <= '0;
      acc_x_q  <= '0;
      acc_y_q  <= '0;
      fsum_x_q <= '0;
      fsum_y_q <= '0;
      axis_q   <= 1'b0;
      err_q    <= 1'b0;
      sat_q    <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (head_i.valid) begin
            unique case (head_i.req.kind)
              KIND_FORCE: begin
                fsum_x_q <= sat(fadd_x);
                fsum_y_q <= sat(fadd_y);
                err_q    <= 1'b0;
                sat_q    <= ovf(fadd_x) || ovf(fadd_y);
              end
              KIND_STEP: begin
                err_q <= mass_zero;
                sat_q <= 1'b0;
              end
              KIND_LOAD: begin
                pos_x_q  <= head_i.req.a_x;
                pos_y_q  <= head_i.req.a_y;
                vel_x_q  <= head_i.req.b_x;
                vel_y_q  <= head_i.req.b_y;
                acc_x_q  <= '0;
                acc_y_q  <= '0;
                fsum_x_q <= '0;
                fsum_y_q <= '0;
                err_q    <= 1'b0;
                sat_q    <= 1'b0;
              end
              KIND_NOP: begin
                err_q <= 1'b0;
                sat_q <= 1'b0;
              end
            endcase
          end
        end
        ST_DIV_X: begin
          if (div_done) begin
            acc_x_q <= acc_val;
            sat_q   <= sat_q || acc_ovf;
          end
        end
        ST_DIV_Y: begin
          if (div_done) begin
            acc_y_q <= acc_val;
            sat_q   <= sat_q || acc_ovf;
            axis_q  <= 1'b0;
          end
        end
        ST_UPDATE: begin
          sat_q <= sat_q || ovf(np) || ovf(nv);
          if (axis_q) begin
            pos_y_q  <= sat(np);
            vel_y_q  <= sat(nv);
            fsum_x_q <= '0;
            fsum_y_q <= '0;
          end else begin
            pos_x_q <= sat(np);
            vel_x_q <= sat(nv);
            axis_q  <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // product registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_MUL_A:  adt_q  <= prod[ADT_W-1:0];
      ST_MUL_V:  vdt_q  <= prod[ADT_W-1:0];
      ST_MUL_A2: adt2_q <= prod[ADT2_W-1:0];
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (out_load) begin
      res_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      res_pos_x_q <= pos_x_q;
      res_pos_y_q <= pos_y_q;
      res_vel_x_q <= vel_x_q;
      res_vel_y_q <= vel_y_q;
      res_acc_x_q <= acc_x_q;
      res_acc_y_q <= acc_y_q;
      res_err_q   <= err_q;
      res_sat_q   <= sat_q;
    end
  end

  assign res_o.valid           = res_valid_q;
  assign res_o.pos_x_out       = res_pos_x_q;
  assign res_o.pos_y_out       = res_pos_y_q;
  assign res_o.vel_x_out       = res_vel_x_q;
  assign res_o.vel_y_out       = res_vel_y_q;
  assign res_o.acc_x_out       = res_acc_x_q;
  assign res_o.acc_y_out       = res_acc_y_q;
  assign res_o.zero_mass_error = res_err_q;
  assign res_o.saturated       = res_sat_q;

endmodule

// ===== sv/newtonian_force_integrator_top.sv =====
// ----------------------------------------------------------------------------
// newtonian_force_integrator_top: 2D point mass with fixed point integration
// Force add, integration step and load requests, one result per request.
// ----------------------------------------------------------------------------
// Every request transaction yields exactly one result transaction carrying
// the position, velocity and last acceleration after the request, plus the
// zero mass and saturation flags. Requests enter a two-entry queue, so up to
// two requests are accepted ahead while the back end works or a result
// waits. Force add, load, refused steps and the unused code go from the
// idle state straight to the done state. An integration step runs the
// serial restoring divider, which produces one quotient bit per cycle,
// once per axis, then for each axis makes three passes through the shared
// multiplier and an update of position and velocity. Configuration writes are
// always accepted and must be issued only while no request is in flight.
module newtonian_force_integrator_top import nfi_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  nfi_req_if.sink   req_i,
  nfi_cfg_if.sink   cfg_i,
  nfi_res_if.source res_o
);

  queue_head_t head;
  logic        pop;

  // intake and queue
  nfi_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .head_o (head),
    .pop_i  (pop)
  );

  // execution
  nfi_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .head_i (head),
    .pop_o  (pop),
    .cfg_i  (cfg_i),
    .res_o  (res_o)
  );

endmodule

// ===== bench/nfi_motion_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// nfi_motion_checker: scoreboard of the force integrator
// Watches the request, configuration and result channels, keeps its own
// copy of the body state, predicts the motion state after each request
// transaction and compares every result transaction field by field.
// ----------------------------------------------------------------------------
module nfi_motion_checker import nfi_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  nfi_req_if          req_i,
  nfi_cfg_if          cfg_i,
  nfi_res_if          res_i,
  output int unsigned fail_count_o,
  output int unsigned outstanding_o
);

  typedef longint unsigned u64_t;
  typedef logic signed [DATA_W-1:0] q_t;

  // State reported by one result transaction
  typedef struct {
    q_t   pos_x;
    q_t   pos_y;
    q_t   vel_x;
    q_t   vel_y;
    q_t   acc_x;
    q_t   acc_y;
    logic zero_mass;
    logic clipped;
  } motion_t;

  localparam longint S32_MAX     = 64'sd2147483647;
  localparam longint S32_MIN     = -64'sd2147483648;

  // Predicted body and register copies
  logic [DATA_W-1:0] mass_q;
  logic [DT_W-1:0]   dt_q;
  q_t                pos_x, pos_y, vel_x, vel_y, acc_x, acc_y;
  q_t                force_x, force_y;

  motion_t           expected_motion_q[$];
  int unsigned       fails;

  // Clip to the 32 bit signed range, flag when clipped
  function automatic q_t clip32(longint x, inout logic hit);
    if (x > S32_MAX) begin
      hit = 1'b1;
      return q_t'(S32_MAX);
    end
    if (x < S32_MIN) begin
      hit = 1'b1;
      return q_t'(S32_MIN);
    end
    return q_t'(x);
  endfunction

  // Divide by 2^n, round to nearest with ties toward plus infinity
  function automatic longint round_half_up(longint x, int n);
    return (x + (64'sd1 <<< (n - 1))) >>> n;
  endfunction

  // force * 2^FRAC / mass on the magnitude, truncated toward zero
  function automatic q_t accel_of(q_t f, inout logic hit);
    u64_t mag, quo;
    mag = (f < 0) ? u64_t'(-longint'(f)) : u64_t'(longint'(f));
    quo = (mag << FRAC_BITS) / u64_t'(mass_q);
    if (f < 0) begin
      if (quo > 64'd2147483648) begin
        hit = 1'b1;
        quo = 64'd2147483648;
      end
      return clip32(-longint'(quo), hit);
    end
    if (quo > 64'd2147483647) begin
      hit = 1'b1;
      quo = 64'd2147483647;
    end
    return q_t'(quo);
  endfunction

  // p += v*dt + a*dt^2/2, v += a*dt, products exact
  function automatic void advance_axis(inout q_t p, inout q_t v, input q_t a,
                                       inout logic hit);
    longint dt, a_dt, v_dt, a_dt2, p_next, v_next;
    dt     = longint'(dt_q);
    a_dt   = longint'(a) * dt;
    v_dt   = longint'(v) * dt;
    a_dt2  = a_dt * dt;
    p_next = longint'(p) + round_half_up(v_dt, DT_W)
             + round_half_up(a_dt2, 2 * DT_W + 1);
    v_next = longint'(v) + round_half_up(a_dt, DT_W);
    p = clip32(p_next, hit);
    v = clip32(v_next, hit);
  endfunction

  // Apply one request to the predicted body, return the state it reports
  function automatic motion_t predict_motion(logic [REQ_W-1:0] code, q_t ax,
                                             q_t ay, q_t bx, q_t by);
    motion_t r;
    logic    hit;
    logic    err;
    hit = 1'b0;
    err = 1'b0;
    case (code)
      REQ_CODE_FORCE: begin
        force_x = clip32(longint'(force_x) + longint'(ax), hit);
        force_y = clip32(longint'(force_y) + longint'(ay), hit);
      end
      REQ_CODE_STEP: begin
        // zero mass refuses the step and keeps the force sum
        if (mass_q == '0) begin
          err = 1'b1;
        end else begin
          acc_x = accel_of(force_x, hit);
          acc_y = accel_of(force_y, hit);
          advance_axis(pos_x, vel_x, acc_x, hit);
          advance_axis(pos_y, vel_y, acc_y, hit);
          force_x = '0;
          force_y = '0;
        end
      end
      REQ_CODE_LOAD: begin
        pos_x   = ax;
        pos_y   = ay;
        vel_x   = bx;
        vel_y   = by;
        acc_x   = '0;
        acc_y   = '0;
        force_x = '0;
        force_y = '0;
      end
      default: ;  // unused code leaves the body alone
    endcase
    r = '{pos_x, pos_y, vel_x, vel_y, acc_x, acc_y, err, hit};
    return r;
  endfunction

  task automatic note_failure(string msg);
    fails++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic check_field(string name, logic [DATA_W-1:0] got,
                             logic [DATA_W-1:0] want);
    if (got !== want)
      note_failure($sformatf("%s got %08h expected %08h", name, got, want));
  endtask

  // Channel monitor: config copy, result compare, request prediction
  always @(posedge clk_i or negedge rst_ni) begin : watch
    motion_t want;
    if (!rst_ni) begin
      mass_q  = MASS_RESET;
      dt_q    = DT_RESET;
      pos_x   = '0;
      pos_y   = '0;
      vel_x   = '0;
      vel_y   = '0;
      acc_x   = '0;
      acc_y   = '0;
      force_x = '0;
      force_y = '0;
      fails   = 0;
      expected_motion_q.delete();
      fail_count_o  <= 0;
      outstanding_o <= 0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          CFG_BODY_MASS: mass_q = cfg_i.data;
          CFG_TIME_STEP: dt_q = cfg_i.data[DT_W-1:0];
          default: ;
        endcase
      end
      if (res_i.valid && res_i.ready) begin
        if (expected_motion_q.size() == 0) begin
          note_failure("result transaction with no request outstanding");
        end else begin
          want = expected_motion_q.pop_front();
          check_field("pos_x", res_i.pos_x_out, want.pos_x);
          check_field("pos_y", res_i.pos_y_out, want.pos_y);
          check_field("vel_x", res_i.vel_x_out, want.vel_x);
          check_field("vel_y", res_i.vel_y_out, want.vel_y);
          check_field("acc_x", res_i.acc_x_out, want.acc_x);
          check_field("acc_y", res_i.acc_y_out, want.acc_y);
          check_field("zero_mass_error", DATA_W'(res_i.zero_mass_error),
                      DATA_W'(want.zero_mass));
          check_field("saturated", DATA_W'(res_i.saturated),
                      DATA_W'(want.clipped));
        end
      end
      if (req_i.valid && req_i.ready) begin
        expected_motion_q.push_back(predict_motion(req_i.req_type,
          req_i.vec_a_x, req_i.vec_a_y, req_i.vec_b_x, req_i.vec_b_y));
      end
      fail_count_o  <= fails;
      outstanding_o <= expected_motion_q.size();
    end
  end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the newtonian force integrator
// Drives directed and random force, step, load and unused requests through
// several mass and time step settings with random idling on both sides;
// the checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_top;
  import nfi_pkg::*;

  localparam logic [REQ_W-1:0] REQ_CODE_UNUSED = 2'd3;
  localparam int IDLE_PCT    = 27;
  localparam int PHASE_ITEMS = 105;
  localparam int NUM_PHASES  = 7;
  localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] Q_ONE = 32'sh0001_0000;

  logic        clk_i;
  logic        rst_ni;
  logic        no_idle;
  int unsigned fail_count;
  int unsigned outstanding;

  nfi_req_if req_bus();
  nfi_cfg_if cfg_bus();
  nfi_res_if res_bus();

  newtonian_force_integrator_top u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_bus),
    .cfg_i  (cfg_bus),
    .res_o  (res_bus)
  );

  nfi_motion_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_i         (req_bus),
    .cfg_i         (cfg_bus),
    .res_i         (res_bus),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding)
  );

  // 100 MHz clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Run limit
  initial begin
    #6_000_000;
    $display("tb_top NOT OK");
    $finish;
  end

  // Result side back-pressure
  always @(posedge clk_i) begin
    res_bus.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
  end

  // Mostly small and unit-scale values, some full range and extremes
  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(5))
      0, 1: return DATA_W'($urandom_range(32'h0020_0000)) - 32'sh0010_0000;
      2: return DATA_W'($urandom_range(32'h0200_0000)) - 32'sh0100_0000;
      3: return $urandom;
      4: begin
        case ($urandom_range(3))
          0: return Q_MAX;
          1: return Q_MIN;
          2: return '0;
          default: return '1;
        endcase
      end
      default: return DATA_W'($urandom_range(32'h0002_0000)) - Q_ONE;
    endcase
  endfunction

  // One request transaction, with random idle cycles ahead of it
  task automatic send_req(logic [REQ_W-1:0] code, logic signed [DATA_W-1:0] a_x,
                          logic signed [DATA_W-1:0] a_y,
                          logic signed [DATA_W-1:0] b_x,
                          logic signed [DATA_W-1:0] b_y);
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      req_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_bus.valid    <= 1'b1;
    req_bus.req_type <= code;
    req_bus.vec_a_x  <= a_x;
    req_bus.vec_a_y  <= a_y;
    req_bus.vec_b_x  <= b_x;
    req_bus.vec_b_y  <= b_y;
    do @(posedge clk_i); while (!req_bus.ready);
  endtask

  // Stop sending and wait until every result is back
  task automatic settle();
    req_bus.valid <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] value);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    do @(posedge clk_i); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic configure(logic [DATA_W-1:0] mass, logic [DT_W-1:0] step);
    settle();
    write_cfg(CFG_BODY_MASS, mass);
    write_cfg(CFG_TIME_STEP, DATA_W'(step));
  endtask

  // Force adds mostly, then steps; loads and unused codes now and then
  task automatic random_item();
    int unsigned      roll;
    logic [REQ_W-1:0] code;
    roll = $urandom_range(99);
    if (roll < 45) code = REQ_CODE_FORCE;
    else if (roll < 78) code = REQ_CODE_STEP;
    else if (roll < 92) code = REQ_CODE_LOAD;
    else code = REQ_CODE_UNUSED;
    send_req(code, pick_value(), pick_value(), pick_value(), pick_value());
  endtask

  // Stimulus and verdict
  initial begin : stimulus
    logic [DATA_W-1:0] mass;
    logic [DT_W-1:0]   step;
    rst_ni           = 1'b0;
    no_idle          = 1'b0;
    req_bus.valid    = 1'b0;
    req_bus.req_type = '0;
    req_bus.vec_a_x  = '0;
    req_bus.vec_a_y  = '0;
    req_bus.vec_b_x  = '0;
    req_bus.vec_b_y  = '0;
    cfg_bus.valid    = 1'b0;
    cfg_bus.index    = '0;
    cfg_bus.data     = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: extremes of position and velocity, force sum overflow
    send_req(REQ_CODE_LOAD, Q_MAX, Q_MIN, Q_MAX, Q_MIN);
    send_req(REQ_CODE_STEP, '0, '0, '0, '0);
    send_req(REQ_CODE_STEP, Q_MIN, Q_MAX, Q_MIN, Q_MAX);
    send_req(REQ_CODE_FORCE, Q_MAX, Q_MIN, '0, '0);
    send_req(REQ_CODE_FORCE, Q_MAX, Q_MIN, '0, '0);
    send_req(REQ_CODE_STEP, '0, '0, '0, '0);
    send_req(REQ_CODE_UNUSED, Q_MIN, Q_MAX, Q_MIN, Q_MAX);
    send_req(REQ_CODE_LOAD, '0, '0, '1, Q_ONE);
    send_req(REQ_CODE_FORCE, Q_ONE, -Q_ONE, Q_MAX, Q_MIN);
    send_req(REQ_CODE_STEP, '0, '0, '0, '0);

    // Zero mass refuses steps and keeps the force sum
    configure('0, DT_RESET);
    send_req(REQ_CODE_FORCE, 32'sh0002_0000, 32'sh0002_0000, '0, '0);
    send_req(REQ_CODE_STEP, '0, '0, '0, '0);
    send_req(REQ_CODE_STEP, '0, '0, '0, '0);

    // Smallest mass, longest step: acceleration clips
    configure(32'd1, 16'hFFFF);
    send_req(REQ_CODE_FORCE, 32'sd1, -32'sd1, '0, '0);
    send_req(REQ_CODE_STEP, '0, '0, '0, '0);
    send_req(REQ_CODE_FORCE, Q_MIN, Q_MAX, '0, '0);
    send_req(REQ_CODE_STEP, '0, '0, '0, '0);

    // Largest mass, zero step
    configure(32'hFFFF_FFFF, '0);
    send_req(REQ_CODE_FORCE, Q_MAX, Q_MIN, '0, '0);
    send_req(REQ_CODE_STEP, '0, '0, '0, '0);
    send_req(REQ_CODE_LOAD, Q_MAX, Q_MAX, Q_MAX, Q_MAX);
    send_req(REQ_CODE_STEP, '0, '0, '0, '0);

    // Random phases, one setting each; phase 4 runs without idling
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: begin mass = MASS_RESET; step = DT_RESET; end
        1: begin
          mass = $urandom_range(32'h0040_0000, 32'h0000_1000);
          step = DT_W'($urandom_range(16'hFFFF));
        end
        2: begin mass = 32'd1; step = 16'hFFFF; end
        3: begin mass = 32'hFFFF_FFFF; step = DT_W'($urandom_range(16'hFFFF)); end
        4: begin mass = $urandom; step = DT_W'($urandom_range(16'hFFFF)); end
        5: begin mass = '0; step = DT_W'($urandom_range(16'hFFFF)); end
        default: begin
          mass = $urandom_range(32'h0010_0000, 32'h0000_4000);
          step = DT_W'($urandom_range(16'hFFFF));
        end
      endcase
      configure(mass, step);
      no_idle <= (ph == 4);
      repeat ((mass == '0) ? 40 : PHASE_ITEMS) random_item();
    end

    // Drain, then allow for the longest step
    req_bus.valid <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
    repeat (120) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
